@@ src/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// Field widths, operation codes and status codes shared by the
// longest-prefix-match table and its checker.
// ----------------------------------------------------------------------------
package lpm_pkg;

    // field widths of one transaction
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int PLEN_W   = 6;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int RES_W    = 32;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((KEY_W + PLEN_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    // bit positions inside s_tdata
    localparam int KEY_LSB  = 0;
    localparam int PLEN_LSB = KEY_W;
    localparam int VAL_LSB  = KEY_W + PLEN_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

endpackage

@@ src/lpm_ram.sv @@
// ----------------------------------------------------------------------------
// lpm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/longest_prefix_match_table.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_match_table
// Table of (prefix, length, value) entries with insert, delete, exact get,
// longest-prefix lookup and clear operations.
// ----------------------------------------------------------------------------
// All entries sit in one RAM with a registered read. Insert, delete, get
// and lookup each walk every slot of that RAM through its single read port:
// the scan state reads every slot in turn, the wait state takes the last
// read data, and the finish state writes back and registers the result,
// waiting while the output register still holds an untaken result. Clear
// writes every slot invalid through the write port and then goes to the
// finish state; unused operation codes go straight to it. After reset the same
// clearing pass runs with s_tready low. The result sits in an output register,
// so a new transaction is taken while the previous result still waits.
module longest_prefix_match_table
    import lpm_pkg::*;
#(
    parameter int KEY_BYTES  = 4,
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key[31:0], plen[5:0], value[31:0], pad
    input  logic [OP_W-1:0]       s_tuser,   // operation[2:0]
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // result_value[31:0]
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    localparam int KEY_BITS = KEY_BYTES * 8;
    localparam int LEN_W    = $clog2(KEY_BITS + 1);
    localparam int ADDR_W   = $clog2(ENTRIES);

    typedef struct packed {
        logic                  valid;
        logic [LEN_W-1:0]      len;
        logic [KEY_BITS-1:0]   prefix;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;

    // keeps the top l bits of a key
    function automatic logic [KEY_BITS-1:0] len_mask(input logic [LEN_W-1:0] l);
        len_mask = ~({KEY_BITS{1'b1}} >> l);
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     idx_reg, idx_next;
    logic                  clear_resp_reg, clear_resp_next;

    logic [OP_W-1:0]       op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   prefix_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [VALUE_BITS-1:0] val_reg;

    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_slot_reg;

    logic                  exact_found_reg, exact_found_next;
    logic [ADDR_W-1:0]     exact_slot_reg, exact_slot_next;
    logic [VALUE_BITS-1:0] exact_val_reg, exact_val_next;
    logic                  free_found_reg, free_found_next;
    logic [ADDR_W-1:0]     free_slot_reg, free_slot_next;
    logic                  best_found_reg, best_found_next;
    logic [LEN_W-1:0]      best_len_reg, best_len_next;
    logic [VALUE_BITS-1:0] best_val_reg, best_val_next;

    logic                  out_valid_reg, out_valid_next;
    logic [RES_W-1:0]      out_data_reg, out_data_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    entry_t                ram_wentry;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_rdata;
    entry_t                rd_entry;

    logic                  in_accept;
    logic                  out_free;
    logic                  idx_last;
    logic [KEY_BITS-1:0]   in_key;
    logic [PLEN_W-1:0]     in_plen;
    logic [LEN_W-1:0]      in_len;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign idx_last  = (idx_reg == ADDR_W'(ENTRIES - 1));
    assign rd_entry  = entry_t'(ram_rdata);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);
    assign m_tuser  = out_status_reg;

    // input field unpacking with length saturation
    assign in_key  = KEY_BITS'(s_tdata[KEY_LSB +: KEY_W]);
    assign in_plen = s_tdata[PLEN_LSB +: PLEN_W];
    always_comb begin
        if (8'(in_plen) > 8'(KEY_BITS)) begin
            in_len = LEN_W'(KEY_BITS);
        end else begin
            in_len = LEN_W'(in_plen);
        end
    end

    // entry store
    lpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign ram_re = (state_reg == ST_SCAN);

    // per-slot evaluation of returning read data
    always_comb begin
        exact_found_next = exact_found_reg;
        exact_slot_next  = exact_slot_reg;
        exact_val_next   = exact_val_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        best_found_next  = best_found_reg;
        best_len_next    = best_len_reg;
        best_val_next    = best_val_reg;
        if (in_accept) begin
            exact_found_next = 1'b0;
            free_found_next  = 1'b0;
            best_found_next  = 1'b0;
        end else if (rd_valid_reg) begin
            if (rd_entry.valid && rd_entry.len == len_reg &&
                rd_entry.prefix == prefix_reg && !exact_found_reg) begin
                exact_found_next = 1'b1;
                exact_slot_next  = rd_slot_reg;
                exact_val_next   = rd_entry.value;
            end
            if (!rd_entry.valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_slot_next  = rd_slot_reg;
            end
            if (rd_entry.valid &&
                (key_reg & len_mask(rd_entry.len)) == rd_entry.prefix &&
                (!best_found_reg || rd_entry.len > best_len_reg)) begin
                best_found_next = 1'b1;
                best_len_next   = rd_entry.len;
                best_val_next   = rd_entry.value;
            end
        end
    end

    // sequencer, write-back and result
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        clear_resp_next = clear_resp_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wentry      = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    idx_next = '0;
                    if (s_tuser == OP_CLEAR) begin
                        clear_resp_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end else if (s_tuser == OP_INSERT || s_tuser == OP_DELETE ||
                                 s_tuser == OP_GET || s_tuser == OP_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_FINISH;
            end
            ST_CLEAR: begin
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_last) begin
                    state_next = clear_resp_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = STATUS_NOTFOUND;
                    state_next      = ST_IDLE;
                    unique case (op_reg)
                        OP_INSERT: begin
                            ram_wentry.valid  = 1'b1;
                            ram_wentry.len    = len_reg;
                            ram_wentry.prefix = prefix_reg;
                            ram_wentry.value  = val_reg;
                            if (exact_found_reg) begin
                                ram_we          = 1'b1;
                                ram_waddr       = exact_slot_reg;
                                out_status_next = STATUS_OK;
                            end else if (free_found_reg) begin
                                ram_we          = 1'b1;
                                ram_waddr       = free_slot_reg;
                                out_status_next = STATUS_OK;
                            end else begin
                                out_status_next = STATUS_FULL;
                            end
                        end
                        OP_DELETE: begin
                            if (exact_found_reg) begin
                                ram_we          = 1'b1;
                                ram_waddr       = exact_slot_reg;
                                out_status_next = STATUS_OK;
                            end
                        end
                        OP_GET: begin
                            if (exact_found_reg) begin
                                out_data_next   = RES_W'(exact_val_reg);
                                out_status_next = STATUS_OK;
                            end
                        end
                        OP_LOOKUP: begin
                            if (best_found_reg) begin
                                out_data_next   = RES_W'(best_val_reg);
                                out_status_next = STATUS_OK;
                            end
                        end
                        OP_CLEAR: begin
                            out_status_next = STATUS_OK;
                        end
                        default: begin
                            out_status_next = STATUS_NOTFOUND;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            clear_resp_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            clear_resp_reg <= clear_resp_next;
            rd_valid_reg   <= ram_re;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_slot_reg     <= idx_reg;
        exact_found_reg <= exact_found_next;
        exact_slot_reg  <= exact_slot_next;
        exact_val_reg   <= exact_val_next;
        free_found_reg  <= free_found_next;
        free_slot_reg   <= free_slot_next;
        best_found_reg  <= best_found_next;
        best_len_reg    <= best_len_next;
        best_val_reg    <= best_val_next;
        out_data_reg    <= out_data_next;
        out_status_reg  <= out_status_next;
        if (in_accept) begin
            op_reg     <= s_tuser;
            key_reg    <= in_key;
            len_reg    <= in_len;
            prefix_reg <= in_key & len_mask(in_len);
            val_reg    <= VALUE_BITS'(s_tdata[VAL_LSB +: VAL_W]);
        end
    end

endmodule

@@ src/lpm_checker.sv @@
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks for the longest-prefix-match table, bound to the top.
// ----------------------------------------------------------------------------
module lpm_checker
    import lpm_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,   // key[31:0], plen[5:0], value[31:0], pad
    input logic [OP_W-1:0]       s_tuser,   // operation[2:0]
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,   // result_value[31:0]
    input logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // result value is zero unless the status is ok
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
        else $error("nonzero result with failing status");

    // one transaction at a time: ready drops after an accepted transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in progress");

    // ready and result valid are low right after reset while the table is swept
    a_reset_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready && !m_tvalid)
        else $error("traffic right after reset");

endmodule

bind longest_prefix_match_table lpm_checker u_lpm_checker (.*);

@@ tb/sv/longest_prefix_match_table_test.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_match_table_test
// Self-checking bench for the longest-prefix-match table: directed checks
// of every operation and corner case, a fill to capacity, a long output
// stall, then random route traffic against a slot-accurate table predictor.
// ----------------------------------------------------------------------------
module longest_prefix_match_table_test;
    import lpm_pkg::*;

    localparam int KEY_BYTES      = 4;
    localparam int TABLE_SLOTS    = 64;
    localparam int VALUE_BITS     = 32;
    localparam int KEY_BITS       = 8 * KEY_BYTES;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_WAIT       = 5;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * TABLE_SLOTS + 16;
    localparam int POOL_DEPTH     = 200;

    // operation codes the block leaves unused
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RES_W-1:0]    value;
    } route_result_t;

    typedef struct {
        logic [KEY_W-1:0] key;
        int               len;
    } route_t;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    // predictor copy of the table
    bit               slot_valid [TABLE_SLOTS];
    int               slot_len   [TABLE_SLOTS];
    logic [KEY_W-1:0] slot_prefix[TABLE_SLOTS];
    logic [VAL_W-1:0] slot_value [TABLE_SLOTS];

    route_result_t expected_results[$];
    route_t        route_pool[$];
    int            error_count = 0;
    int            stall_cycles = 0;
    bit            idle_free = 1'b0;
    bit            hold_request = 1'b0;

    longest_prefix_match_table #(
        .KEY_BYTES (KEY_BYTES),
        .ENTRIES   (TABLE_SLOTS),
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // keeps the top len bits of a key
    function automatic logic [KEY_W-1:0] prefix_mask(input int len);
        if (len == 0) begin
            return '0;
        end
        return {KEY_W{1'b1}} << (KEY_BITS - len);
    endfunction

    function automatic int clamp_len(input logic [PLEN_W-1:0] plen);
        return (plen > KEY_BITS) ? KEY_BITS : int'(plen);
    endfunction

    function automatic int find_route_slot(input logic [KEY_W-1:0] prefix, input int len);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_valid[i] && slot_len[i] == len && slot_prefix[i] == prefix) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int table_occupancy();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_valid[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // applies one operation to the predicted table and returns its result
    function automatic route_result_t apply_table_op(input logic [OP_W-1:0]   op,
                                                     input logic [KEY_W-1:0]  key,
                                                     input logic [PLEN_W-1:0] plen,
                                                     input logic [VAL_W-1:0]  val);
        route_result_t    r;
        int               len;
        int               slot;
        int               best;
        logic [KEY_W-1:0] prefix;
        r.status = STATUS_NOTFOUND;
        r.value  = '0;
        len      = clamp_len(plen);
        prefix   = key & prefix_mask(len);
        slot     = find_route_slot(prefix, len);
        case (op)
            OP_INSERT: begin
                // new routes take the lowest free slot
                if (slot < 0) begin
                    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
                        if (!slot_valid[i]) begin
                            slot = i;
                        end
                    end
                end
                if (slot < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    slot_valid[slot]  = 1'b1;
                    slot_len[slot]    = len;
                    slot_prefix[slot] = prefix;
                    slot_value[slot]  = val;
                    r.status          = STATUS_OK;
                end
            end
            OP_DELETE: begin
                if (slot >= 0) begin
                    slot_valid[slot] = 1'b0;
                    r.status         = STATUS_OK;
                end
            end
            OP_GET: begin
                if (slot >= 0) begin
                    r.value  = slot_value[slot];
                    r.status = STATUS_OK;
                end
            end
            OP_LOOKUP: begin
                // strictly longer wins, so ties keep the lower slot
                best = -1;
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (slot_valid[i] && (key & prefix_mask(slot_len[i])) == slot_prefix[i]
                        && (best < 0 || slot_len[i] > slot_len[best])) begin
                        best = i;
                    end
                end
                if (best >= 0) begin
                    r.value  = slot_value[best];
                    r.status = STATUS_OK;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    slot_valid[i] = 1'b0;
                end
                r.status = STATUS_OK;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // offers one transaction and returns once it has been accepted
    task automatic send_op(input logic [OP_W-1:0]   op,
                           input logic [KEY_W-1:0]  key,
                           input logic [PLEN_W-1:0] plen,
                           input logic [VAL_W-1:0]  val);
        logic [IN_DATA_W-1:0] data;
        int                   gap;
        data = '0;
        data[KEY_LSB +: KEY_W]   = key;
        data[PLEN_LSB +: PLEN_W] = plen;
        data[VAL_LSB +: VAL_W]   = val;
        gap = idle_free ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_INSERT) begin
            route_pool.push_back('{key: key & prefix_mask(clamp_len(plen)), len: clamp_len(plen)});
            if (route_pool.size() > POOL_DEPTH) begin
                void'(route_pool.pop_front());
            end
        end
    endtask

    // result acceptance and prediction of each accepted transaction
    always @(posedge aclk) begin : result_check
        route_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d value %h",
                                          m_tuser, m_tdata));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                end
                if (m_tdata[RES_W-1:0] !== want.value) begin
                    report_mismatch($sformatf("result value %h, expected %h",
                                              m_tdata[RES_W-1:0], want.value));
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            expected_results.push_back(apply_table_op(s_tuser, s_tdata[KEY_LSB +: KEY_W],
                                                      s_tdata[PLEN_LSB +: PLEN_W],
                                                      s_tdata[VAL_LSB +: VAL_W]));
        end
    end

    // result receiver with random stalls and an occasional long hold
    initial begin : result_receiver
        int wait_cycles;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            wait_cycles = idle_free ? 0 : $urandom_range(0, MAX_WAIT);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // picks a route that was inserted earlier, or a random one
    function automatic route_t pick_route();
        route_t r;
        if (route_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
            r.key = $urandom();
            r.len = $urandom_range(0, KEY_BITS);
        end else begin
            r = route_pool[$urandom_range(0, route_pool.size() - 1)];
        end
        return r;
    endfunction

    // key equal to the route in its top len bits, random below
    function automatic logic [KEY_W-1:0] key_under(input route_t r);
        return (r.key & prefix_mask(r.len)) | (KEY_W'($urandom()) & ~prefix_mask(r.len));
    endfunction

    // prefix length field for a route, sometimes written above the key width
    function automatic logic [PLEN_W-1:0] length_field(input int len);
        if (len == KEY_BITS && $urandom_range(0, 2) == 0) begin
            return PLEN_W'($urandom_range(KEY_BITS + 1, 2 ** PLEN_W - 1));
        end
        return PLEN_W'(len);
    endfunction

    task automatic test_empty_table();
        send_op(OP_GET, 32'h0000_0000, 6'd0, 32'h0);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
        send_op(OP_DELETE, 32'h0A00_0000, 6'd8, 32'h0);
        send_op(OP_CLEAR, 32'h0, 6'd0, 32'h0);
    endtask

    task automatic test_exact_and_longest_match();
        // default route: low bits of the key are ignored
        send_op(OP_INSERT, 32'hDEAD_BEEF, 6'd0, 32'h0000_0D0F);
        send_op(OP_INSERT, 32'h0A00_0000, 6'd8, 32'h0000_0008);
        send_op(OP_INSERT, 32'h0A01_FFFF, 6'd16, 32'h0000_0016);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
        send_op(OP_LOOKUP, 32'h0A02_0000, 6'd63, 32'hFFFF_FFFF);
        send_op(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
        send_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
        send_op(OP_GET, 32'h0A00_0000, 6'd8, 32'h0);
        send_op(OP_GET, 32'h0A00_0000, 6'd9, 32'h0);
        // overwrite with the same prefix and length
        send_op(OP_INSERT, 32'h0AFF_FFFF, 6'd8, 32'h0000_0000);
        send_op(OP_GET, 32'h0A12_3456, 6'd8, 32'h0);
        send_op(OP_DELETE, 32'h0A01_0000, 6'd16, 32'h0);
        send_op(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
        send_op(OP_DELETE, 32'h0A01_0000, 6'd16, 32'h0);
        send_op(OP_DELETE, 32'h0000_0000, 6'd0, 32'h0);
        send_op(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
    endtask

    task automatic test_length_saturation();
        // lengths above the key width act as full-width host routes
        send_op(OP_INSERT, 32'h1234_5678, 6'd63, 32'hA5A5_5A5A);
        send_op(OP_GET, 32'h1234_5678, 6'd32, 32'h0);
        send_op(OP_GET, 32'h1234_5678, 6'd40, 32'h0);
        send_op(OP_LOOKUP, 32'h1234_5678, 6'd0, 32'h0);
        send_op(OP_DELETE, 32'h1234_5678, 6'd33, 32'h0);
    endtask

    task automatic test_reserved_opcodes();
        for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++) begin
            send_op(OP_W'(op), 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        end
        send_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
    endtask

    task automatic test_table_full();
        send_op(OP_CLEAR, 32'h0, 6'd0, 32'h0);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_op(OP_INSERT, {24'($urandom()), 8'(i)}, 6'd32, $urandom());
        end
        send_op(OP_INSERT, 32'hC0A8_0000, 6'd16, 32'h1111_1111);
        // overwriting an existing route still works when full
        send_op(OP_INSERT, route_pool[route_pool.size() - 2].key, 6'd32, 32'h2222_2222);
        send_op(OP_DELETE, route_pool[route_pool.size() - 10].key, 6'd32, 32'h0);
        send_op(OP_INSERT, 32'hC0A8_0000, 6'd16, 32'h3333_3333);
        send_op(OP_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0);
        send_op(OP_INSERT, 32'hC0A9_0000, 6'd16, 32'h4444_4444);
        send_op(OP_CLEAR, 32'h0, 6'd0, 32'h0);
    endtask

    task automatic test_output_backpressure();
        send_op(OP_INSERT, 32'h0, 6'd0, 32'h5555_AAAA);
        idle_free    = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_op(OP_LOOKUP, $urandom(), 6'd0, 32'h0);
        end
        idle_free = 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        route_t           r;
        int               pick;
        int               insert_limit;
        logic [KEY_W-1:0] key;
        for (int n = 0; n < count; n++) begin
            pick         = $urandom_range(0, 99);
            insert_limit = (table_occupancy() > 48) ? 25 : 40;
            r            = pick_route();
            if (pick < 2) begin
                send_op(OP_CLEAR, $urandom(), PLEN_W'($urandom()), $urandom());
            end else if (pick < 5) begin
                send_op(OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), $urandom(),
                        PLEN_W'($urandom()), $urandom());
            end else if (pick < insert_limit) begin
                // half the time nest a route of equal or greater length under the picked one
                if ($urandom_range(0, 1) == 0) begin
                    r.len = $urandom_range(r.len, KEY_BITS);
                end else if ($urandom_range(0, 3) == 0) begin
                    r.len = 8 * $urandom_range(0, KEY_BYTES);
                end
                key = key_under(r);
                send_op(OP_INSERT, key, length_field(r.len), $urandom());
            end else if (pick < 55) begin
                send_op(OP_DELETE, key_under(r), length_field(r.len), $urandom());
            end else if (pick < 68) begin
                send_op(OP_GET, key_under(r), length_field(r.len), $urandom());
            end else begin
                send_op(OP_LOOKUP, key_under(r), PLEN_W'($urandom()), $urandom());
            end
        end
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_table();
        test_exact_and_longest_match();
        test_length_saturation();
        test_reserved_opcodes();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(500);
        idle_free = 1'b1;
        test_random_traffic(150);
        idle_free = 1'b0;
        test_random_traffic(600);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ longest_prefix_match_table.f @@
src/lpm_pkg.sv
src/lpm_ram.sv
src/longest_prefix_match_table.sv
src/lpm_checker.sv
tb/sv/longest_prefix_match_table_test.sv
